FILE: hdl/prru_pkg.sv
package prru_pkg;

    localparam int MAX_ELEMENTS = 12;
    localparam int EL_W         = 4;
    localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int M_W          = $clog2(MAX_ELEMENTS + 1);
    localparam int PERM_W       = 48;
    localparam int RANK_W       = 29;
    localparam int RECIP_W      = 32;
    localparam int PROD_W       = RANK_W + RECIP_W;
    localparam int LEN_W        = 4;
    localparam int DATA_W       = ((PERM_W + RANK_W + 7) / 8) * 8;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(12);

    localparam logic CMD_RANK   = 1'b0;
    localparam logic CMD_UNRANK = 1'b1;

    typedef logic [EL_W-1:0]  t_elem;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [M_W-1:0]   t_m;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic init;
        logic rstep;
        logic umul;
        logic ustep;
        t_m   m;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic bad_init;
    } t_dp_stat;

    typedef struct packed {
        logic              bad_input;
        logic [PERM_W-1:0] perm_out;
        logic [RANK_W-1:0] rank_out;
    } t_result;

    // floor((2^32 - 1) / m); quotient estimate is low by at most one
    function automatic logic [RECIP_W-1:0] recip(input t_m m);
        logic [RECIP_W-1:0] r;
        r = '1;
        case (5'(m))
            5'd1:    r = 32'hFFFF_FFFF;
            5'd2:    r = 32'h7FFF_FFFF;
            5'd3:    r = 32'h5555_5555;
            5'd4:    r = 32'h3FFF_FFFF;
            5'd5:    r = 32'h3333_3333;
            5'd6:    r = 32'h2AAA_AAAA;
            5'd7:    r = 32'h2492_4924;
            5'd8:    r = 32'h1FFF_FFFF;
            5'd9:    r = 32'h1C71_C71C;
            5'd10:   r = 32'h1999_9999;
            5'd11:   r = 32'h1745_D174;
            5'd12:   r = 32'h1555_5555;
            5'd13:   r = 32'h13B1_3B13;
            5'd14:   r = 32'h1249_2492;
            5'd15:   r = 32'h1111_1111;
            5'd16:   r = 32'h0FFF_FFFF;
            default: r = '1;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/permutation_rank_unrank_unit.sv
// Channel     | Dir | Handshake           | Payload
// s_axis      | in  | tvalid / tready     | tdata: perm_in, rank_in; tuser: cmd
// m_axis      | out | tvalid / tready     | tdata: rank_out, perm_out; tuser: bad_input
// cfg         | in  | wr_en               | wr_data: perm_length
//
// One request at a time. From accept, rank runs a check step, a swap for each m
// from n down to 2 and a load into the output register; unrank runs a reciprocal
// multiply, then correction and swap, for each m from n down to 2, then the load.
// A bad permutation or an n below 2 skips straight to the load.
// Ready returns in the cycle after the result is loaded; a waiting result does not
// block the next request, a second finished result holds until the first is taken.
// Reset is synchronous, active low; perm_length resets to 12.
module permutation_rank_unrank_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // perm_in [47:0], rank_in [76:48], zero [79:77]
    input  logic [prru_pkg::DATA_W-1:0]  i_s_axis_tdata,
    // cmd [0]
    input  logic [0:0]                   i_s_axis_tuser,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // rank_out [28:0], perm_out [76:29], zero [79:77]
    output logic [prru_pkg::DATA_W-1:0]  o_m_axis_tdata,
    // bad_input [0]
    output logic [0:0]                   o_m_axis_tuser,
    input  logic                         i_cfg_wr_en,
    input  logic [prru_pkg::LEN_W-1:0]   i_cfg_wr_data
);

    logic [prru_pkg::LEN_W-1:0] r_perm_length;
    logic                       r_out_valid;
    prru_pkg::t_result          r_out;

    prru_pkg::t_m        len;
    prru_pkg::t_dp_cmd   dp_cmd;
    prru_pkg::t_dp_stat  dp_stat;
    prru_pkg::t_result   dp_result;
    logic                ready;
    logic                deliver;
    logic                start;
    logic                out_free;

    // zero counts as one element, anything above the maximum is clamped
    always_comb begin
        if (r_perm_length == '0) begin
            len = prru_pkg::M_W'(1);
        end else if (5'(r_perm_length) > 5'(prru_pkg::MAX_ELEMENTS)) begin
            len = prru_pkg::M_W'(prru_pkg::MAX_ELEMENTS);
        end else begin
            len = prru_pkg::M_W'(r_perm_length);
        end
    end

    assign start    = i_s_axis_tvalid && ready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    prru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_start_cmd (i_s_axis_tuser[0]),
        .i_len       (len),
        .i_stat      (dp_stat),
        .i_out_free  (out_free),
        .o_cmd       (dp_cmd),
        .o_ready     (ready),
        .o_deliver   (deliver)
    );

    prru_dp u_dp (
        .i_clk     (i_clk),
        .i_cmd     (dp_cmd),
        .i_len     (len),
        .i_req_cmd (i_s_axis_tuser[0]),
        .i_perm_in (i_s_axis_tdata[prru_pkg::PERM_W-1:0]),
        .i_rank_in (i_s_axis_tdata[prru_pkg::PERM_W +: prru_pkg::RANK_W]),
        .o_stat    (dp_stat),
        .o_result  (dp_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_length <= prru_pkg::LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_perm_length <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (deliver) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (deliver) begin
            r_out <= dp_result;
        end
    end

    assign o_s_axis_tready = ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = prru_pkg::DATA_W'({r_out.perm_out, r_out.rank_out});
    assign o_m_axis_tuser  = r_out.bad_input;

endmodule

FILE: hdl/prru_ctrl.sv
module prru_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_start_cmd,
    input  prru_pkg::t_m      i_len,
    input  prru_pkg::t_dp_stat i_stat,
    input  logic              i_out_free,
    output prru_pkg::t_dp_cmd o_cmd,
    output logic              o_ready,
    output logic              o_deliver
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_INIT  = 6'b000010,
        ST_RSTEP = 6'b000100,
        ST_UMUL  = 6'b001000,
        ST_USTEP = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state       r_state, n_state;
    prru_pkg::t_m r_m, n_m;

    always_comb begin
        n_state   = r_state;
        n_m       = r_m;
        o_cmd     = '0;
        o_cmd.m   = r_m;
        o_ready   = 1'b0;
        o_deliver = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_start;
                if (i_start) begin
                    n_m = i_len;
                    if (i_start_cmd == prru_pkg::CMD_RANK) begin
                        n_state = ST_INIT;
                    end else if (i_len < prru_pkg::M_W'(2)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_UMUL;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                if (i_stat.bad_init || r_m < prru_pkg::M_W'(2)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_RSTEP;
                end
            end
            ST_RSTEP: begin
                o_cmd.rstep = 1'b1;
                if (r_m == prru_pkg::M_W'(2)) begin
                    n_state = ST_DONE;
                end else begin
                    n_m = r_m - prru_pkg::M_W'(1);
                end
            end
            ST_UMUL: begin
                o_cmd.umul = 1'b1;
                n_state    = ST_USTEP;
            end
            ST_USTEP: begin
                o_cmd.ustep = 1'b1;
                if (r_m == prru_pkg::M_W'(2)) begin
                    n_state = ST_DONE;
                end else begin
                    n_m     = r_m - prru_pkg::M_W'(1);
                    n_state = ST_UMUL;
                end
            end
            ST_DONE: begin
                o_deliver = i_out_free;
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            r_m     <= n_m;
        end
    end

endmodule

FILE: hdl/prru_dp.sv
module prru_dp (
    input  logic                          i_clk,
    input  prru_pkg::t_dp_cmd             i_cmd,
    input  prru_pkg::t_m                  i_len,
    input  logic                          i_req_cmd,
    input  logic [prru_pkg::PERM_W-1:0]   i_perm_in,
    input  logic [prru_pkg::RANK_W-1:0]   i_rank_in,
    output prru_pkg::t_dp_stat            o_stat,
    output prru_pkg::t_result             o_result
);

    localparam int N = prru_pkg::MAX_ELEMENTS;

    prru_pkg::t_elem                r_p   [N];
    prru_pkg::t_idx                 r_inv [N];
    logic                           r_op;
    logic                           r_bad;
    logic [prru_pkg::RANK_W-1:0]    r_rank;
    logic [prru_pkg::RANK_W-1:0]    r_w;
    logic [prru_pkg::RANK_W-1:0]    r_r;
    logic [prru_pkg::RANK_W-1:0]    r_prod;
    prru_pkg::t_elem                r_hold;

    prru_pkg::t_idx                 m_idx;
    prru_pkg::t_idx                 rd_addr;
    prru_pkg::t_elem                rd_p;
    prru_pkg::t_idx                 pos;
    logic [N-1:0]                   found;
    prru_pkg::t_idx                 inv_init [N];
    logic                           bad_init;
    logic [prru_pkg::RANK_W-1:0]    term;
    logic [prru_pkg::RANK_W-1:0]    w_next;
    logic [prru_pkg::PROD_W-1:0]    prod_full;
    logic [prru_pkg::RANK_W-1:0]    qm;
    logic [prru_pkg::RANK_W-1:0]    rem_raw;
    logic                           rem_ge;
    logic [prru_pkg::RANK_W-1:0]    rem;
    logic [prru_pkg::RANK_W-1:0]    quot;
    prru_pkg::t_idx                 j;
    logic [prru_pkg::PERM_W-1:0]    packed_p;

    assign m_idx = prru_pkg::IDX_W'(i_cmd.m - prru_pkg::M_W'(1));

    // unrank swap target, from the registered quotient estimate
    assign qm      = prru_pkg::RANK_W'(r_prod * prru_pkg::RANK_W'(i_cmd.m));
    assign rem_raw = r_r - qm;
    assign rem_ge  = rem_raw >= prru_pkg::RANK_W'(i_cmd.m);
    assign rem     = rem_ge ? rem_raw - prru_pkg::RANK_W'(i_cmd.m) : rem_raw;
    assign quot    = rem_ge ? r_prod + prru_pkg::RANK_W'(1) : r_prod;
    assign j       = rem[prru_pkg::IDX_W-1:0];

    // single addressed read port on the element array
    assign rd_addr = i_cmd.ustep ? j : m_idx;
    assign rd_p    = r_p[rd_addr];
    assign pos     = r_inv[m_idx];

    assign term      = prru_pkg::RANK_W'(r_w * prru_pkg::RANK_W'(rd_p));
    assign w_next    = prru_pkg::RANK_W'(r_w * prru_pkg::RANK_W'(i_cmd.m));
    assign prod_full = {{prru_pkg::RECIP_W{1'b0}}, r_r}
                     * {{prru_pkg::RANK_W{1'b0}}, prru_pkg::recip(i_cmd.m)};

    // inverse and validity: every value below n must appear among the first n
    always_comb begin
        bad_init = 1'b0;
        for (int v = 0; v < N; v++) begin
            found[v]    = 1'b0;
            inv_init[v] = '0;
            for (int i = 0; i < N; i++) begin
                if (prru_pkg::M_W'(i) < i_len && r_p[i] == prru_pkg::EL_W'(v)) begin
                    found[v]    = 1'b1;
                    inv_init[v] = prru_pkg::IDX_W'(i);
                end
            end
            if (prru_pkg::M_W'(v) < i_len && !found[v]) begin
                bad_init = 1'b1;
            end
        end
    end

    assign o_stat.bad_init = bad_init;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            packed_p[i*prru_pkg::EL_W +: prru_pkg::EL_W] =
                (prru_pkg::M_W'(i) < i_len) ? r_p[i] : '0;
        end
        for (int i = N * prru_pkg::EL_W; i < prru_pkg::PERM_W; i++) begin
            packed_p[i] = 1'b0;
        end
    end

    always_comb begin
        o_result = '0;
        if (r_op == prru_pkg::CMD_UNRANK) begin
            o_result.perm_out = packed_p;
        end else begin
            o_result.bad_input = r_bad;
            o_result.rank_out  = r_bad ? '0 : r_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req_cmd;
            r_bad  <= 1'b0;
            r_rank <= '0;
            r_w    <= prru_pkg::RANK_W'(1);
            r_r    <= i_rank_in;
            for (int i = 0; i < N; i++) begin
                r_p[i] <= (i_req_cmd == prru_pkg::CMD_RANK)
                        ? i_perm_in[i*prru_pkg::EL_W +: prru_pkg::EL_W]
                        : prru_pkg::EL_W'(i);
            end
        end
        if (i_cmd.init) begin
            r_bad <= bad_init;
            for (int v = 0; v < N; v++) begin
                r_inv[v] <= inv_init[v];
            end
        end
        if (i_cmd.rstep) begin
            // position m-1 and inv[m-1] are never read again, skip their writes
            r_rank <= r_rank + term;
            r_w    <= w_next;
            for (int k = 0; k < N; k++) begin
                if (pos == prru_pkg::IDX_W'(k)) begin
                    r_p[k] <= rd_p;
                end
                if (rd_p == prru_pkg::EL_W'(k)) begin
                    r_inv[k] <= pos;
                end
            end
        end
        if (i_cmd.umul) begin
            r_prod <= prod_full[prru_pkg::PROD_W-1 -: prru_pkg::RANK_W];
            r_hold <= rd_p;
        end
        if (i_cmd.ustep) begin
            r_r <= quot;
            for (int k = 0; k < N; k++) begin
                if (m_idx == prru_pkg::IDX_W'(k)) begin
                    r_p[k] <= rd_p;
                end
                if (j == prru_pkg::IDX_W'(k)) begin
                    r_p[k] <= r_hold;
                end
            end
        end
    end

endmodule

FILE: tb/sv/tb_permutation_rank_unrank_unit.sv
module tb_permutation_rank_unrank_unit;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                        cmd;
        logic [prru_pkg::PERM_W-1:0] perm;
        logic [prru_pkg::RANK_W-1:0] rnk;
    } t_request;

    typedef struct {
        logic [prru_pkg::RANK_W-1:0] rnk;
        logic [prru_pkg::PERM_W-1:0] perm;
        logic                        bad;
    } t_answer;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [prru_pkg::DATA_W-1:0]   s_data = '0;
    logic [0:0]                    s_user = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [prru_pkg::DATA_W-1:0]   m_data;
    logic [0:0]                    m_user;
    logic                          cfg_we = 1'b0;
    logic [prru_pkg::LEN_W-1:0]    cfg_data = '0;

    t_request  request_q[$];
    t_answer   answer_q[$];
    logic [prru_pkg::LEN_W-1:0] cfg_len = prru_pkg::LEN_RESET;
    t_request  cur_req;
    int        mismatches = 0;

    logic [prru_pkg::LEN_W-1:0] lengths [16] = '{4'd0, 4'd1, 4'd15, 4'd13, 4'd2, 4'd3, 4'd4,
                                                4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11,
                                                4'd14, 4'd12};

    // sender burst state
    int burst_left = 8;
    int gap_left = 0;

    // receiver stall state
    int seg_left = 0;
    int seg_mode = 0;
    int hold_left = 0;
    int long_holds = 0;
    int taken = 0;

    permutation_rank_unrank_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_wr_data   (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int length_of(logic [prru_pkg::LEN_W-1:0] len);
        int n;
        n = int'(len);
        if (n < 1) n = 1;
        if (n > prru_pkg::MAX_ELEMENTS) n = prru_pkg::MAX_ELEMENTS;
        return n;
    endfunction

    function automatic longint factorial(int n);
        longint f;
        f = 1;
        for (int i = 2; i <= n; i++) f = f * i;
        return f;
    endfunction

    // linear-time rank: peel off the last position, swapping through the inverse
    function automatic t_answer rank_of_perm(logic [prru_pkg::PERM_W-1:0] packed_perm, int n);
        t_answer a;
        int p[16];
        int inv[16];
        int digit[17];
        bit seen[16];
        int v, s, pos, t;
        longint r;
        a.rnk = '0;
        a.perm = '0;
        a.bad = 1'b0;
        r = 0;
        for (int i = 0; i < 16; i++) seen[i] = 1'b0;
        for (int i = 0; i < n; i++) begin
            v = int'(packed_perm[4*i +: 4]);
            if (v >= n || seen[v]) begin
                a.bad = 1'b1;
                return a;
            end
            seen[v] = 1'b1;
            p[i] = v;
            inv[v] = i;
        end
        for (int m = n; m >= 2; m--) begin
            s = p[m-1];
            pos = inv[m-1];
            t = p[m-1];
            p[m-1] = p[pos];
            p[pos] = t;
            t = inv[s];
            inv[s] = inv[m-1];
            inv[m-1] = t;
            digit[m] = s;
        end
        for (int m = 2; m <= n; m++) r = longint'(digit[m]) + longint'(m) * r;
        a.rnk = prru_pkg::RANK_W'(r);
        return a;
    endfunction

    function automatic t_answer perm_of_rank(logic [prru_pkg::RANK_W-1:0] rnk, int n);
        t_answer a;
        int p[16];
        int j, t;
        longint r;
        a.rnk = '0;
        a.perm = '0;
        a.bad = 1'b0;
        r = longint'(rnk);
        for (int i = 0; i < n; i++) p[i] = i;
        for (int m = n; m >= 1; m--) begin
            j = int'(r % m);
            t = p[m-1];
            p[m-1] = p[j];
            p[j] = t;
            r = r / m;
        end
        for (int i = 0; i < n; i++) a.perm[4*i +: 4] = 4'(p[i]);
        return a;
    endfunction

    function automatic t_answer predict_answer(t_request rq, logic [prru_pkg::LEN_W-1:0] len);
        if (rq.cmd == prru_pkg::CMD_RANK) return rank_of_perm(rq.perm, length_of(len));
        return perm_of_rank(rq.rnk, length_of(len));
    endfunction

    function automatic t_request noise_request(logic cmd);
        t_request rq;
        rq.cmd = cmd;
        rq.perm = prru_pkg::PERM_W'({$urandom(), $urandom()});
        rq.rnk = prru_pkg::RANK_W'($urandom());
        return rq;
    endfunction

    // identity or reversed order in the live positions, garbage above them
    function automatic t_request ordered_request(int n, bit reversed);
        t_request rq;
        rq = noise_request(prru_pkg::CMD_RANK);
        for (int i = 0; i < n; i++) rq.perm[4*i +: 4] = 4'(reversed ? n - 1 - i : i);
        return rq;
    endfunction

    function automatic t_request random_request(int n);
        t_request rq;
        int v[16];
        int pick, a, j, t;
        rq = noise_request($urandom_range(0, 1) ? prru_pkg::CMD_UNRANK : prru_pkg::CMD_RANK);
        if (rq.cmd == prru_pkg::CMD_UNRANK) begin
            if ($urandom_range(0, 3) != 0)
                rq.rnk = prru_pkg::RANK_W'(longint'($urandom()) % factorial(n));
            return rq;
        end
        pick = $urandom_range(0, 9);
        if (pick >= 8) return rq;
        for (int i = 0; i < n; i++) v[i] = i;
        for (int i = n - 1; i >= 1; i--) begin
            j = $urandom_range(0, i);
            t = v[i];
            v[i] = v[j];
            v[j] = t;
        end
        a = $urandom_range(0, n - 1);
        if (pick == 6) v[a] = v[(a + 1) % n];
        else if (pick == 7) v[a] = $urandom_range(n, 15);
        for (int i = 0; i < n; i++) rq.perm[4*i +: 4] = 4'(v[i]);
        return rq;
    endfunction

    task automatic add_edge_requests(int n);
        t_request rq;
        request_q.push_back(ordered_request(n, 1'b0));
        request_q.push_back(ordered_request(n, 1'b1));
        rq = ordered_request(n, 1'b0);
        rq.perm[3:0] = 4'(n);
        request_q.push_back(rq);
        rq = noise_request(prru_pkg::CMD_UNRANK);
        rq.rnk = '0;
        request_q.push_back(rq);
        rq.rnk = prru_pkg::RANK_W'(factorial(n) - 1);
        request_q.push_back(rq);
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || s_valid || answer_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_length(logic [prru_pkg::LEN_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        cfg_len = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic report(string what, longint want, longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0h got %0h", what, want, got);
    endtask

    // driver
    always @(posedge clk) begin : driver
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) answer_q.push_back(predict_answer(cur_req, cfg_len));
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    cur_req = request_q.pop_front();
                    s_data <= {{(prru_pkg::DATA_W - prru_pkg::PERM_W - prru_pkg::RANK_W){1'b0}},
                               cur_req.rnk, cur_req.perm};
                    s_user <= cur_req.cmd;
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(0, 3))
                            0, 1: gap_left = 0;
                            2: gap_left = $urandom_range(1, 4);
                            default: gap_left = $urandom_range(5, 30);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge clk) begin : receiver
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) taken++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (long_holds < 2 && taken >= 100 * (long_holds + 1)
                         && request_q.size() > 8) begin
                // long hold-off: the block fills and must stall its input
                long_holds++;
                hold_left = 400;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 24);
                    seg_mode = $urandom_range(0, 3);
                end
                seg_left--;
                case (seg_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 4) == 0);
                    default: m_ready <= ($urandom_range(0, 5) != 0);
                endcase
            end
        end
    end

    // monitor
    always @(posedge clk) begin : monitor
        t_answer want;
        if (rst_n && m_valid && m_ready) begin
            if (answer_q.size() == 0) begin
                report("unexpected result", 0, longint'(m_data[prru_pkg::RANK_W-1:0]));
            end else begin
                want = answer_q.pop_front();
                if (m_data[prru_pkg::RANK_W-1:0] != want.rnk)
                    report("rank_out", want.rnk, m_data[prru_pkg::RANK_W-1:0]);
                if (m_data[prru_pkg::RANK_W +: prru_pkg::PERM_W] != want.perm)
                    report("perm_out", want.perm, m_data[prru_pkg::RANK_W +: prru_pkg::PERM_W]);
                if (m_user[0] != want.bad)
                    report("bad_input", want.bad, m_user[0]);
            end
        end
    end

    initial begin : timeout
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        t_request rq;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests at the reset length of 12
        request_q.push_back(ordered_request(12, 1'b0));
        request_q.push_back(ordered_request(12, 1'b1));
        rq = ordered_request(12, 1'b0);
        rq.perm[47:44] = 4'd0;
        request_q.push_back(rq);                    // repeated element
        rq = noise_request(prru_pkg::CMD_RANK);
        rq.perm = '1;                               // every element out of range
        rq.rnk = '1;
        request_q.push_back(rq);
        rq.perm = '0;
        request_q.push_back(rq);
        rq = noise_request(prru_pkg::CMD_UNRANK);
        rq.rnk = '0;
        rq.perm = '1;
        request_q.push_back(rq);
        rq.rnk = 29'd479001599;
        request_q.push_back(rq);
        rq.rnk = 29'd479001600;                     // wraps to zero
        request_q.push_back(rq);
        rq.rnk = '1;
        request_q.push_back(rq);
        wait_idle();

        foreach (lengths[k]) begin
            set_length(lengths[k]);
            add_edge_requests(length_of(lengths[k]));
            for (int i = 0; i < 23; i++)
                request_q.push_back(random_request(length_of(lengths[k])));
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/prru_pkg.sv
hdl/prru_ctrl.sv
hdl/prru_dp.sv
hdl/permutation_rank_unrank_unit.sv
tb/sv/tb_permutation_rank_unrank_unit.sv
